// ===== src/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sphere point contact package
// Shared widths, constants and the side-band record that rides the pipeline.
// ----------------------------------------------------------------------------
package spc_pkg;

   // Field widths.
   localparam int COORD_BITS = 32;
   localparam int RAD_BITS   = COORD_BITS - 1;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int SQ_BITS    = 2 * DIFF_BITS;
   localparam int SUM_BITS   = SQ_BITS + 1;
   localparam int NORM_BITS  = 18;
   localparam int QUOT_BITS  = 17;

   // Square root runs one result bit per stage, the divide one quotient bit.
   localparam int SQRT_STEPS = RAD_BITS;
   localparam int DIV_STEPS  = QUOT_BITS;
   localparam int REM_BITS   = RAD_BITS + 4;
   localparam int DREM_BITS  = RAD_BITS + 1;

   // Unit length in Q1.16 and the tiny squared length (0.00001 in Q32.32).
   localparam logic [QUOT_BITS-1:0] NORM_ONE = QUOT_BITS'(65536);
   localparam logic [SUM_BITS-1:0]  TINY_SQ  = SUM_BITS'(42950);

   // Per-item record carried alongside the arithmetic.
   typedef struct packed {
      logic                hit;
      logic                tiny;
      logic [2:0]          neg;
      logic [RAD_BITS-1:0] mag_x;
      logic [RAD_BITS-1:0] mag_y;
      logic [RAD_BITS-1:0] mag_z;
      logic [RAD_BITS-1:0] radius;
   } carry_type;

endpackage

// ===== src/sphere_point_contact_unit.sv =====
// Throughput: one word per cycle unless a stalled rsp word holds the pipeline;
// the 31-stage square root and the 17-stage three-lane divider each retire
// one bit per stage.
// A stalled rsp word freezes the whole pipeline, and req_stall follows it.
// Reset is synchronous and clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
// Sphere point contact unit
// Computes hit, unit normal, contact points and penetration for a sphere
// against a nearest point, fully pipelined.
// ----------------------------------------------------------------------------
module sphere_point_contact_unit
   import spc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_sphere_x,
   input  logic signed [COORD_BITS-1:0] req_sphere_y,
   input  logic signed [COORD_BITS-1:0] req_sphere_z,
   input  logic signed [COORD_BITS-1:0] req_near_x,
   input  logic signed [COORD_BITS-1:0] req_near_y,
   input  logic signed [COORD_BITS-1:0] req_near_z,
   input  logic [RAD_BITS-1:0]          req_radius,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit,
   output logic signed [NORM_BITS-1:0]  rsp_normal_x,
   output logic signed [NORM_BITS-1:0]  rsp_normal_y,
   output logic signed [NORM_BITS-1:0]  rsp_normal_z,
   output logic signed [COORD_BITS-1:0] rsp_contact_a_x,
   output logic signed [COORD_BITS-1:0] rsp_contact_a_y,
   output logic signed [COORD_BITS-1:0] rsp_contact_a_z,
   output logic signed [COORD_BITS-1:0] rsp_contact_b_x,
   output logic signed [COORD_BITS-1:0] rsp_contact_b_y,
   output logic signed [COORD_BITS-1:0] rsp_contact_b_z,
   output logic signed [COORD_BITS-1:0] rsp_penetration
);

   // The pipeline advances unless a finished word is held by the consumer.
   logic advance;
   logic rsp_valid_ff;
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Stage A: offsets, magnitudes and signs.
   logic                 a_valid_ff;
   logic [DIFF_BITS-1:0] a_mag_ff [3];
   logic [2:0]           a_neg_ff;
   logic [RAD_BITS-1:0]  a_radius_ff;
   logic signed [DIFF_BITS-1:0] a_diff_in [3];

   always_comb begin
      a_diff_in[0] = DIFF_BITS'(req_sphere_x) - DIFF_BITS'(req_near_x);
      a_diff_in[1] = DIFF_BITS'(req_sphere_y) - DIFF_BITS'(req_near_y);
      a_diff_in[2] = DIFF_BITS'(req_sphere_z) - DIFF_BITS'(req_near_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff  <= req_valid;
         a_radius_ff <= req_radius;
         for (int i = 0; i < 3; i++) begin
            a_neg_ff[i] <= a_diff_in[i][DIFF_BITS-1];
            a_mag_ff[i] <= a_diff_in[i][DIFF_BITS-1] ? -a_diff_in[i] : a_diff_in[i];
         end
      end
   end

   // Stage B: squares of each offset and of the radius.
   logic                  b_valid_ff;
   logic [SQ_BITS-1:0]    b_sq_ff [3];
   logic [2*RAD_BITS-1:0] b_rr_ff;
   carry_type             b_carry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
         for (int i = 0; i < 3; i++) begin
            b_sq_ff[i] <= a_mag_ff[i] * a_mag_ff[i];
         end
         b_rr_ff           <= a_radius_ff * a_radius_ff;
         b_carry_ff.hit    <= 1'b0;
         b_carry_ff.tiny   <= 1'b0;
         b_carry_ff.neg    <= a_neg_ff;
         b_carry_ff.mag_x  <= a_mag_ff[0][RAD_BITS-1:0];
         b_carry_ff.mag_y  <= a_mag_ff[1][RAD_BITS-1:0];
         b_carry_ff.mag_z  <= a_mag_ff[2][RAD_BITS-1:0];
         b_carry_ff.radius <= a_radius_ff;
      end
   end

   // Stage C: squared length, radius compare and tiny test.
   logic [SUM_BITS-1:0] c_sum_in;
   carry_type           c_carry_in;
   assign c_sum_in = SUM_BITS'(b_sq_ff[0]) + SUM_BITS'(b_sq_ff[1]) + SUM_BITS'(b_sq_ff[2]);

   always_comb begin
      c_carry_in      = b_carry_ff;
      c_carry_in.hit  = c_sum_in <= SUM_BITS'(b_rr_ff);
      c_carry_in.tiny = c_sum_in < TINY_SQ;
   end

   // Square root pipeline, index 0 is stage C.
   logic                  sq_valid_ff [SQRT_STEPS+1];
   logic [REM_BITS-1:0]   sq_rem_ff   [SQRT_STEPS+1];
   logic [RAD_BITS-1:0]   sq_root_ff  [SQRT_STEPS+1];
   logic [2*RAD_BITS-1:0] sq_s_ff     [SQRT_STEPS+1];
   carry_type             sq_carry_ff [SQRT_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff[0] <= 1'b0;
      end else if (advance) begin
         sq_valid_ff[0] <= b_valid_ff;
         sq_rem_ff[0]   <= '0;
         sq_root_ff[0]  <= '0;
         sq_s_ff[0]     <= c_sum_in[2*RAD_BITS-1:0];
         sq_carry_ff[0] <= c_carry_in;
      end
   end

   // One root bit per stage: bring down two bits, try subtracting 4*root+1.
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam int B = SQRT_STEPS - 1 - k;
      logic [REM_BITS-1:0] rem_in;
      logic [REM_BITS-1:0] trial_in;
      assign rem_in   = {sq_rem_ff[k][REM_BITS-3:0], sq_s_ff[k][2*B+1 -: 2]};
      assign trial_in = {1'b0, sq_root_ff[k], 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            sq_valid_ff[k+1] <= sq_valid_ff[k];
            sq_s_ff[k+1]     <= sq_s_ff[k];
            sq_carry_ff[k+1] <= sq_carry_ff[k];
            if (rem_in >= trial_in) begin
               sq_rem_ff[k+1]  <= rem_in - trial_in;
               sq_root_ff[k+1] <= {sq_root_ff[k][RAD_BITS-2:0], 1'b1};
            end else begin
               sq_rem_ff[k+1]  <= rem_in;
               sq_root_ff[k+1] <= {sq_root_ff[k][RAD_BITS-2:0], 1'b0};
            end
         end
      end
   end

   // Divider pipeline, three lanes, index 0 loads from the root.
   // The numerator is mag << 16; its top part mag >> 1 is already below the
   // root, so only the last seventeen numerator bits need steps.
   logic                  dv_valid_ff [DIV_STEPS+1];
   logic [DREM_BITS-1:0]  dv_rem_ff   [DIV_STEPS+1][3];
   logic [QUOT_BITS-1:0]  dv_quot_ff  [DIV_STEPS+1][3];
   logic [RAD_BITS-1:0]   dv_dist_ff  [DIV_STEPS+1];
   logic [2:0]            dv_low_ff   [DIV_STEPS+1];
   carry_type             dv_carry_ff [DIV_STEPS+1];
   carry_type             sq_last;
   assign sq_last = sq_carry_ff[SQRT_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (advance) begin
         dv_valid_ff[0]  <= sq_valid_ff[SQRT_STEPS];
         dv_dist_ff[0]   <= sq_root_ff[SQRT_STEPS];
         dv_carry_ff[0]  <= sq_last;
         dv_rem_ff[0][0] <= DREM_BITS'(sq_last.mag_x[RAD_BITS-1:1]);
         dv_rem_ff[0][1] <= DREM_BITS'(sq_last.mag_y[RAD_BITS-1:1]);
         dv_rem_ff[0][2] <= DREM_BITS'(sq_last.mag_z[RAD_BITS-1:1]);
         dv_low_ff[0]    <= {sq_last.mag_z[0], sq_last.mag_y[0], sq_last.mag_x[0]};
         for (int i = 0; i < 3; i++) begin
            dv_quot_ff[0][i] <= '0;
         end
      end
   end

   // One quotient bit per stage and lane.
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [DREM_BITS-1:0] rem_in [3];
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            rem_in[i] = {dv_rem_ff[j][i][DREM_BITS-2:0], (j == 0) ? dv_low_ff[j][i] : 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j+1] <= 1'b0;
         end else if (advance) begin
            dv_valid_ff[j+1] <= dv_valid_ff[j];
            dv_dist_ff[j+1]  <= dv_dist_ff[j];
            dv_low_ff[j+1]   <= dv_low_ff[j];
            dv_carry_ff[j+1] <= dv_carry_ff[j];
            for (int i = 0; i < 3; i++) begin
               if (rem_in[i] >= DREM_BITS'(dv_dist_ff[j])) begin
                  dv_rem_ff[j+1][i]  <= rem_in[i] - DREM_BITS'(dv_dist_ff[j]);
                  dv_quot_ff[j+1][i] <= {dv_quot_ff[j][i][QUOT_BITS-2:0], 1'b1};
               end else begin
                  dv_rem_ff[j+1][i]  <= rem_in[i];
                  dv_quot_ff[j+1][i] <= {dv_quot_ff[j][i][QUOT_BITS-2:0], 1'b0};
               end
            end
         end
      end
   end

   // Stage M: pick the normal (tiny offsets use the x axis) and scale by radius.
   carry_type                    dv_last;
   logic [QUOT_BITS-1:0]         m_norm_in [3];
   logic                         m_valid_ff;
   logic [QUOT_BITS-1:0]         m_norm_ff [3];
   logic [QUOT_BITS+RAD_BITS-1:0] m_prod_ff [3];
   logic [2:0]                   m_neg_ff;
   logic [RAD_BITS-1:0]          m_dist_ff;
   logic [RAD_BITS-1:0]          m_radius_ff;
   logic                         m_hit_ff;
   assign dv_last = dv_carry_ff[DIV_STEPS];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_last.tiny) begin
            m_norm_in[i] = (i == 0) ? NORM_ONE : '0;
         end else begin
            m_norm_in[i] = dv_quot_ff[DIV_STEPS][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (advance) begin
         m_valid_ff  <= dv_valid_ff[DIV_STEPS];
         m_neg_ff    <= dv_last.tiny ? 3'b000 : dv_last.neg;
         m_dist_ff   <= dv_last.tiny ? '0 : dv_dist_ff[DIV_STEPS];
         m_radius_ff <= dv_last.radius;
         m_hit_ff    <= dv_last.hit;
         for (int i = 0; i < 3; i++) begin
            m_norm_ff[i] <= m_norm_in[i];
            m_prod_ff[i] <= m_norm_in[i] * dv_last.radius;
         end
      end
   end

   // Output stage: signs, penetration and zeroing on a miss.
   logic [COORD_BITS-1:0] o_scaled [3];
   logic                  rsp_hit_ff;
   logic [NORM_BITS-1:0]  rsp_norm_ff [3];
   logic [COORD_BITS-1:0] rsp_ca_ff   [3];
   logic [COORD_BITS-1:0] rsp_cb_ff   [3];
   logic [COORD_BITS-1:0] rsp_pen_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         o_scaled[i] = COORD_BITS'(m_prod_ff[i][QUOT_BITS+RAD_BITS-1:16]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= m_valid_ff;
         rsp_hit_ff   <= m_hit_ff;
         rsp_pen_ff   <= m_hit_ff ? COORD_BITS'(m_dist_ff) - COORD_BITS'(m_radius_ff) : '0;
         for (int i = 0; i < 3; i++) begin
            if (!m_hit_ff) begin
               rsp_norm_ff[i] <= '0;
               rsp_ca_ff[i]   <= '0;
               rsp_cb_ff[i]   <= '0;
            end else if (m_neg_ff[i]) begin
               rsp_norm_ff[i] <= -NORM_BITS'(m_norm_ff[i]);
               rsp_ca_ff[i]   <= -o_scaled[i];
               rsp_cb_ff[i]   <= o_scaled[i];
            end else begin
               rsp_norm_ff[i] <= NORM_BITS'(m_norm_ff[i]);
               rsp_ca_ff[i]   <= o_scaled[i];
               rsp_cb_ff[i]   <= -o_scaled[i];
            end
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_normal_x    = rsp_norm_ff[0];
   assign rsp_normal_y    = rsp_norm_ff[1];
   assign rsp_normal_z    = rsp_norm_ff[2];
   assign rsp_contact_a_x = rsp_ca_ff[0];
   assign rsp_contact_a_y = rsp_ca_ff[1];
   assign rsp_contact_a_z = rsp_ca_ff[2];
   assign rsp_contact_b_x = rsp_cb_ff[0];
   assign rsp_contact_b_y = rsp_cb_ff[1];
   assign rsp_contact_b_z = rsp_cb_ff[2];
   assign rsp_penetration = rsp_pen_ff;

   // A miss word carries zeros in every field; this checks penetration, normal_x and contact_a_x.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_penetration == '0 && rsp_normal_x == '0
                                && rsp_contact_a_x == '0)
      else $error("miss word has nonzero fields");

   // A hit never reports positive penetration.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_penetration[COORD_BITS-1] || rsp_penetration == '0)
      else $error("positive penetration on hit");

   // Contact B is the exact negation of contact A; this checks the y axis.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_contact_a_y + rsp_contact_b_y == '0)
      else $error("contact points not opposite");

endmodule

// ===== test/sphere_point_contact_unit_test.sv =====
// ----------------------------------------------------------------------------
// Sphere point contact unit testbench
// Drives sphere and nearest-point words with random idle bursts on both sides.
// Every rsp word is checked against an in-bench contact calculation.
// Directed cases cover misses, tiny offsets, zero radius and extreme values.
// ----------------------------------------------------------------------------
module sphere_point_contact_unit_test
   import spc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 120;

   typedef struct {
      logic                        hit;
      logic signed [NORM_BITS-1:0]  normal [3];
      logic signed [COORD_BITS-1:0] contact_a [3];
      logic signed [COORD_BITS-1:0] contact_b [3];
      logic signed [COORD_BITS-1:0] penetration;
   } contact_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [COORD_BITS-1:0] req_sphere_x, req_sphere_y, req_sphere_z;
   logic signed [COORD_BITS-1:0] req_near_x, req_near_y, req_near_z;
   logic [RAD_BITS-1:0] req_radius;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_hit;
   logic signed [NORM_BITS-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic signed [COORD_BITS-1:0] rsp_contact_a_x, rsp_contact_a_y, rsp_contact_a_z;
   logic signed [COORD_BITS-1:0] rsp_contact_b_x, rsp_contact_b_y, rsp_contact_b_z;
   logic signed [COORD_BITS-1:0] rsp_penetration;

   contact_type expected_contacts [$];
   int  error_count;
   int  idle_cycles;
   bit  quiet_mode;

   sphere_point_contact_unit dut (.*);

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Contact calculation for one word, kept in wide integers.
   function automatic contact_type compute_contact(
      logic signed [COORD_BITS-1:0] sx, sy, sz, nx, ny, nz,
      logic [RAD_BITS-1:0] rad);
      contact_type c;
      logic signed [DIFF_BITS-1:0] offs [3];
      logic [DIFF_BITS-1:0] amag [3];
      bit neg [3];
      logic [127:0] sq_len, rad_sq, cand, quot;
      logic [63:0] root_len, nmag [3], amag_out [3];
      c.hit = 1'b0;
      c.penetration = '0;
      for (int i = 0; i < 3; i++) begin
         c.normal[i] = '0;
         c.contact_a[i] = '0;
         c.contact_b[i] = '0;
      end
      offs[0] = DIFF_BITS'(sx) - DIFF_BITS'(nx);
      offs[1] = DIFF_BITS'(sy) - DIFF_BITS'(ny);
      offs[2] = DIFF_BITS'(sz) - DIFF_BITS'(nz);
      sq_len = '0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = offs[i] < 0;
         amag[i] = neg[i] ? DIFF_BITS'(-offs[i]) : DIFF_BITS'(offs[i]);
         sq_len += 128'(amag[i]) * 128'(amag[i]);
      end
      rad_sq = 128'(rad) * 128'(rad);
      if (sq_len > rad_sq) return c;
      root_len = '0;
      if (sq_len < 128'(42950)) begin
         nmag[0] = 65536; nmag[1] = 0; nmag[2] = 0;
         neg[0] = 0; neg[1] = 0; neg[2] = 0;
      end else begin
         // Bitwise integer square root.
         for (int b = COORD_BITS - 2; b >= 0; b--) begin
            cand = 128'(root_len | (64'd1 << b));
            if (cand * cand <= sq_len) root_len = cand[63:0];
         end
         for (int i = 0; i < 3; i++) begin
            quot = (root_len == 0) ? '0 : (128'(amag[i]) << 16) / 128'(root_len);
            nmag[i] = quot > 65536 ? 64'd65536 : quot[63:0];
         end
      end
      c.hit = 1'b1;
      for (int i = 0; i < 3; i++) begin
         amag_out[i] = (nmag[i] * 64'(rad)) >> 16;
         c.normal[i] = neg[i] ? NORM_BITS'(-nmag[i]) : NORM_BITS'(nmag[i]);
         c.contact_a[i] = neg[i] ? COORD_BITS'(-amag_out[i]) : COORD_BITS'(amag_out[i]);
         c.contact_b[i] = neg[i] ? COORD_BITS'(amag_out[i]) : COORD_BITS'(-amag_out[i]);
      end
      c.penetration = COORD_BITS'(root_len - 64'(rad));
      return c;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      error_count++;
   endtask

   // Send one word, with an optional idle burst before it.
   task automatic send_word(logic signed [COORD_BITS-1:0] sx, sy, sz, nx, ny, nz,
                            logic [RAD_BITS-1:0] rad);
      int gap;
      if (!quiet_mode && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_sphere_x <= sx; req_sphere_y <= sy; req_sphere_z <= sz;
      req_near_x   <= nx; req_near_y   <= ny; req_near_z   <= nz;
      req_radius   <= rad;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_contacts.push_back(compute_contact(sx, sy, sz, nx, ny, nz, rad));
      @(negedge clock);
   endtask

   // Receiver stall bursts.
   initial begin
      int burst;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 8);
            rsp_stall <= 1'b1;
            repeat (burst) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Result checking.
   initial begin
      contact_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_contacts.size() == 0) begin
               $display("unexpected rsp word at %0t", $realtime);
               error_count++;
            end else begin
               want = expected_contacts.pop_front();
               if (rsp_hit !== want.hit) report_mismatch("hit", rsp_hit, want.hit);
               if (rsp_normal_x !== want.normal[0])
                  report_mismatch("normal_x", rsp_normal_x, want.normal[0]);
               if (rsp_normal_y !== want.normal[1])
                  report_mismatch("normal_y", rsp_normal_y, want.normal[1]);
               if (rsp_normal_z !== want.normal[2])
                  report_mismatch("normal_z", rsp_normal_z, want.normal[2]);
               if (rsp_contact_a_x !== want.contact_a[0])
                  report_mismatch("contact_a_x", rsp_contact_a_x, want.contact_a[0]);
               if (rsp_contact_a_y !== want.contact_a[1])
                  report_mismatch("contact_a_y", rsp_contact_a_y, want.contact_a[1]);
               if (rsp_contact_a_z !== want.contact_a[2])
                  report_mismatch("contact_a_z", rsp_contact_a_z, want.contact_a[2]);
               if (rsp_contact_b_x !== want.contact_b[0])
                  report_mismatch("contact_b_x", rsp_contact_b_x, want.contact_b[0]);
               if (rsp_contact_b_y !== want.contact_b[1])
                  report_mismatch("contact_b_y", rsp_contact_b_y, want.contact_b[1]);
               if (rsp_contact_b_z !== want.contact_b[2])
                  report_mismatch("contact_b_z", rsp_contact_b_z, want.contact_b[2]);
               if (rsp_penetration !== want.penetration)
                  report_mismatch("penetration", rsp_penetration, want.penetration);
            end
         end
      end
   end

   // Watchdog on cycles without any accepted word.
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $realtime);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   function automatic logic signed [COORD_BITS-1:0] random_coord();
      return COORD_BITS'($urandom);
   endfunction

   // Directed extremes and special cases.
   task automatic test_directed();
      logic signed [COORD_BITS-1:0] cmax, cmin;
      logic [RAD_BITS-1:0] rmax;
      cmax = {1'b0, {(COORD_BITS-1){1'b1}}};
      cmin = {1'b1, {(COORD_BITS-1){1'b0}}};
      rmax = '1;
      // A coincident point with zero radius is a tiny-offset hit.
      send_word(0, 0, 0, 0, 0, 0, 0);
      send_word(32'h10000, 0, 0, 0, 0, 0, 0);
      // Offsets just under and just over the tiny threshold.
      send_word(207, 0, 0, 0, 0, 0, 31'h10000);
      send_word(208, 0, 0, 0, 0, 0, 31'h10000);
      send_word(cmax, cmax, cmax, cmax, cmax, cmax, rmax);
      // Axis aligned hits with each sign, then a 3-4-5 offset on and just outside the sphere.
      send_word(32'h10000, 0, 0, 0, 0, 0, 31'h20000);
      send_word(0, -32'sh10000, 0, 0, 0, 0, 31'h20000);
      send_word(0, 0, 32'h18000, 0, 0, 0, 31'h18000);
      send_word(32'h30000, 32'h40000, 0, 0, 0, 0, 31'h50000);
      send_word(32'h30000, 32'h40000, 0, 0, 0, 0, 31'h4ffff);
      // Largest radius, with the largest offsets first and then mixed ones.
      send_word(cmax, cmax, cmax, cmin, cmin, cmin, rmax);
      send_word(cmin, 0, 0, cmax, 0, 0, rmax);
      send_word(cmax, 0, 0, 0, 0, 0, rmax);
      send_word(cmin, 0, 0, 0, 0, 0, rmax);
      send_word(0, cmin, 0, 0, 0, 0, rmax);
      send_word(0, 0, cmax, 0, 0, 0, rmax);
      send_word(-1, -1, -1, 0, 0, 0, rmax);
      send_word(32'h1234_5678, -32'sh0765_4321, 32'h0abc_def0, 0, 0, 0, rmax);
   endtask

   // Random words: mostly hits with the radius at or above the offset length.
   task automatic test_random(int count);
      logic signed [COORD_BITS-1:0] sx, sy, sz, nx, ny, nz;
      logic signed [COORD_BITS-1:0] dx, dy, dz;
      logic [RAD_BITS-1:0] rad;
      int scale, mode;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(0, 9);
         sx = random_coord(); sy = random_coord(); sz = random_coord();
         if (mode < 7) begin
            scale = $urandom_range(1, 29);
            dx = $signed($urandom) >>> (31 - scale);
            dy = $signed($urandom) >>> (31 - scale);
            dz = $signed($urandom) >>> (31 - scale);
            nx = sx - dx; ny = sy - dy; nz = sz - dz;
            rad = RAD_BITS'((64'd1 << (scale + 1)) + $urandom_range(0, 3) *
                            (64'd1 << scale) + ($urandom >> (31 - scale)));
            if (mode == 6) rad = RAD_BITS'($urandom >> (32 - scale));
         end else if (mode == 7) begin
            nx = sx + COORD_BITS'($urandom_range(0, 300)) - 150;
            ny = sy; nz = sz;
            rad = RAD_BITS'($urandom);
         end else begin
            nx = random_coord(); ny = random_coord(); nz = random_coord();
            rad = RAD_BITS'($urandom);
         end
         send_word(sx, sy, sz, nx, ny, nz, rad);
      end
   endtask

   // Main sequence.
   initial begin
      error_count   = 0;
      quiet_mode    = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_sphere_x = '0; req_sphere_y = '0; req_sphere_z = '0;
      req_near_x   = '0; req_near_y   = '0; req_near_z   = '0;
      req_radius   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(900);
      quiet_mode = 1'b1;
      test_random(100);
      req_valid <= 1'b0;
      while (expected_contacts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/spc_pkg.sv
src/sphere_point_contact_unit.sv
test/sphere_point_contact_unit_test.sv
